// ===== sv/cda_pkg.sv =====
// ----------------------------------------------------------------------------
// cda_pkg: shared types and constants
// Widths of the element parts, the per-element terms and the term queue.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int IN_W    = 16;           // one Q1.15 part
  localparam int PROD_W  = 2 * IN_W;     // exact Q2.30 product
  localparam int TERM_W  = PROD_W + 1;   // sum or difference of two products
  localparam int OUT_W   = 48;           // result sums
  localparam int WIDE_W  = 64;           // sign-extension width before truncation
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // One classified element: both conj(x)*y terms and the end-of-vector mark.
  typedef struct packed {
    logic signed [TERM_W-1:0] t_re;
    logic signed [TERM_W-1:0] t_im;
    logic                     last;
  } term_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/cda_front.sv =====
// ----------------------------------------------------------------------------
// cda_front: input stage
// Accepts element pairs, registers the four products and forms both terms.
// ----------------------------------------------------------------------------
module cda_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic signed [cda_pkg::IN_W-1:0]    x_real,
  input  logic signed [cda_pkg::IN_W-1:0]    x_imag,
  input  logic signed [cda_pkg::IN_W-1:0]    y_real,
  input  logic signed [cda_pkg::IN_W-1:0]    y_imag,
  input  logic                               final_element,
  input  cda_pkg::q_stat_t                   q_stat,
  output logic                               q_push,
  output cda_pkg::term_t                     q_wdata
);

  logic                                 p_valid_r, p_valid_nxt;
  logic signed [cda_pkg::PROD_W-1:0]    p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                                 p_last_r;

  // The product stage moves whenever it is empty or its item goes to the queue.
  assign in_tready   = !p_valid_r || !q_stat.full;
  assign q_push      = p_valid_r && !q_stat.full;
  assign p_valid_nxt = in_tready ? in_tvalid : p_valid_r;

  always_comb begin
    q_wdata.t_re = cda_pkg::TERM_W'(p_rr_r) + cda_pkg::TERM_W'(p_ii_r);
    q_wdata.t_im = cda_pkg::TERM_W'(p_ri_r) - cda_pkg::TERM_W'(p_ir_r);
    q_wdata.last = p_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else begin
      p_valid_r <= p_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      p_rr_r   <= x_real * y_real;
      p_ii_r   <= x_imag * y_imag;
      p_ri_r   <= x_real * y_imag;
      p_ir_r   <= x_imag * y_real;
      p_last_r <= final_element;
    end
  end

endmodule

// ===== sv/cda_queue.sv =====
// ----------------------------------------------------------------------------
// cda_queue: term queue
// Small register FIFO that decouples the product stage from the accumulators.
// ----------------------------------------------------------------------------
module cda_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cda_pkg::term_t    wdata,
  input  logic              pop,
  output cda_pkg::term_t    rdata,
  output cda_pkg::q_stat_t  stat
);

  cda_pkg::term_t                 mem_r [cda_pkg::Q_DEPTH];
  logic [cda_pkg::Q_PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [cda_pkg::Q_PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [cda_pkg::Q_CNT_W-1:0]    count_r, count_nxt;

  assign stat.full  = (count_r == cda_pkg::Q_CNT_W'(cda_pkg::Q_DEPTH));
  assign stat.empty = (count_r == '0);
  assign rdata      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/cda_back.sv =====
// ----------------------------------------------------------------------------
// cda_back: accumulator stage
// Saturating accumulation of the terms and the result register.
// ----------------------------------------------------------------------------
module cda_back #(
  parameter int ACC_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cda_pkg::term_t                    q_rdata,
  input  cda_pkg::q_stat_t                  q_stat,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [cda_pkg::OUT_W-1:0]  sum_real,
  output logic signed [cda_pkg::OUT_W-1:0]  sum_imag,
  output logic                              saturated
);

  localparam int SUM_W = ACC_BITS + 1;

  logic signed [ACC_BITS-1:0]        acc_re_r, acc_re_nxt;
  logic signed [ACC_BITS-1:0]        acc_im_r, acc_im_nxt;
  logic                              clip_r, clip_nxt;
  logic                              out_valid_r, out_valid_nxt;
  logic signed [cda_pkg::OUT_W-1:0]  out_re_r, out_im_r;
  logic                              out_sat_r;
  logic [ACC_BITS:0]                 add_re, add_im;
  logic signed [ACC_BITS-1:0]        new_re, new_im;
  logic                              new_clip;
  logic signed [cda_pkg::WIDE_W-1:0] wide_re, wide_im;
  logic                              emit;

  // Returns {clip, value}: the accumulator plus the term, clamped to the rails.
  function automatic logic [ACC_BITS:0] sat_add(
    input logic signed [ACC_BITS-1:0]         acc,
    input logic signed [cda_pkg::TERM_W-1:0]  term
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(acc) + SUM_W'(term);
    if (s[SUM_W-1] != s[SUM_W-2]) begin
      return {1'b1, s[SUM_W-1], {(ACC_BITS-1){~s[SUM_W-1]}}};
    end
    return {1'b0, s[ACC_BITS-1:0]};
  endfunction

  // A final element needs the result register free; other elements never wait.
  assign q_pop = !q_stat.empty && (!q_rdata.last || !out_valid_r || out_ready);
  assign emit  = q_pop && q_rdata.last;

  always_comb begin
    add_re   = sat_add(acc_re_r, q_rdata.t_re);
    add_im   = sat_add(acc_im_r, q_rdata.t_im);
    new_re   = add_re[ACC_BITS-1:0];
    new_im   = add_im[ACC_BITS-1:0];
    new_clip = clip_r | add_re[ACC_BITS] | add_im[ACC_BITS];
    wide_re  = cda_pkg::WIDE_W'(new_re);
    wide_im  = cda_pkg::WIDE_W'(new_im);

    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    clip_nxt   = clip_r;
    if (emit) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
      clip_nxt   = 1'b0;
    end else if (q_pop) begin
      acc_re_nxt = new_re;
      acc_im_nxt = new_im;
      clip_nxt   = new_clip;
    end

    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_re_r    <= '0;
      acc_im_r    <= '0;
      clip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_re_r    <= acc_re_nxt;
      acc_im_r    <= acc_im_nxt;
      clip_r      <= clip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_re_r  <= wide_re[cda_pkg::OUT_W-1:0];
      out_im_r  <= wide_im[cda_pkg::OUT_W-1:0];
      out_sat_r <= new_clip;
    end
  end

  assign out_valid = out_valid_r;
  assign sum_real  = out_re_r;
  assign sum_imag  = out_im_r;
  assign saturated = out_sat_r;

endmodule

// ===== sv/complex_conj_dot_accumulator.sv =====
// ----------------------------------------------------------------------------
// complex_conj_dot_accumulator: streaming complex conjugate dot product
// Accumulates conj(x)*y over a vector in two saturating accumulators.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one element pair per transfer: x and y, each a
//   complex value with signed Q1.15 parts, and in_tlast on the last pair of
//   a vector. The real sum gathers xr*yr + xi*yi and the imaginary sum
//   gathers xr*yi - xi*yr, both exact per element and saturated only in the
//   ACC_BITS-wide accumulators. On the last pair one result transfer leaves
//   on the output stream: both sums as signed Q18.30 and, in out_tuser, a
//   flag that tells whether either accumulator clipped within the vector.
//   The accumulators then start over from zero.
//   Throughput is one element per cycle while in_tready is high. The last
//   element of a vector passes the product register and the term queue;
//   then the result register takes both sums and raises out_tvalid.
//   Reset (synchronous, rst_n low) clears the accumulators, the queue and the
//   result register. When the receiver stalls, the finished result waits in
//   the result register while the elements of the next vector keep being
//   accumulated; only the next last element waits, and once the four-entry
//   term queue fills, in_tready drops.
// ----------------------------------------------------------------------------
module complex_conj_dot_accumulator #(
  parameter int ACC_BITS = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // x_real[15:0], x_imag[31:16], y_real[47:32], y_imag[63:48]
  input  logic        in_tlast,   // final_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,  // sum_real[47:0], sum_imag[95:48]
  output logic        out_tuser   // saturated
);

  cda_pkg::term_t                   q_wdata, q_rdata;
  cda_pkg::q_stat_t                 q_stat;
  logic                             q_push, q_pop;
  logic signed [cda_pkg::OUT_W-1:0] sum_real, sum_imag;

  // Front: accept the pair and form both per-element terms.
  cda_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .x_real        (in_tdata[15:0]),
    .x_imag        (in_tdata[31:16]),
    .y_real        (in_tdata[47:32]),
    .y_imag        (in_tdata[63:48]),
    .final_element (in_tlast),
    .q_stat        (q_stat),
    .q_push        (q_push),
    .q_wdata       (q_wdata)
  );

  // Queue between the product stage and the accumulators.
  cda_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  // Back: saturating accumulation and the result register.
  cda_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_rdata   (q_rdata),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sum_real  (sum_real),
    .sum_imag  (sum_imag),
    .saturated (out_tuser)
  );

  assign out_tdata = {sum_imag, sum_real};

  // The front never writes into a full queue.
  a_no_push_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("term written into a full queue");

  // A result is only produced when the result register is free or draining.
  a_no_result_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_rdata.last && out_tvalid) |-> out_tready)
    else $error("pending result overwritten");

  // The back never pops an empty queue.
  a_no_pop_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from an empty queue");

  // Reset leaves no result pending.
  a_reset_clears_output : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule
